// ===== rtl/core/trps_pkg.sv =====
// Shared types, constants and codes for the tree routing parent selector.
package trps_pkg;

    // Defaults for the top-level parameters
    localparam int NEIGHBOR_SLOTS_DEF = 5;
    localparam int MAX_NODES_DEF      = 15;
    localparam int HOP_SLOTS_DEF      = 5;

    // Fixed field widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Routing constants
    localparam logic [7:0] NO_ADDR        = 8'hff;
    localparam logic [7:0] LEVEL_RESET    = 8'h7f;
    localparam logic [7:0] LEVEL_NONE     = 8'hff;
    localparam logic [7:0] LEVEL_CAP      = 8'd8;
    localparam logic [3:0] ROUTE_RELOAD   = 4'd10;
    localparam logic [7:0] POT_LOW        = 8'd60;
    localparam logic [7:0] POT_HIGH       = 8'd80;
    localparam logic [2:0] FWD_HOLD       = 3'd4;
    localparam logic [2:0] BEACON_PERIOD  = 3'd2;
    localparam logic [2:0] BEACON_HOPS    = 3'd1;

    // Configuration register reset values
    localparam logic [3:0] NODE_ADDR_RST  = 4'd1;
    localparam logic [7:0] DIVIDER_RST    = 8'd4;
    localparam logic [7:0] RETRY_RST      = 8'd3;
    localparam logic [7:0] THRESHOLD_RST  = 8'd25;

    typedef enum logic [1:0] {
        CMD_MESSAGE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_SAMPLE  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        SEND_NONE    = 2'd0,
        SEND_BEACON  = 2'd1,
        SEND_FORWARD = 2'd2
    } t_send_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ADDRESS   = 2'd0,
        CFG_INIT_DIVIDER   = 2'd1,
        CFG_INIT_RETRY     = 2'd2,
        CFG_THRESHOLD      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0] node_address;
        logic [7:0] change_threshold;
    } t_cfg;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] last_hop_source;
        logic [7:0] next_hop_source;
        logic [2:0] hops_seen;
        logic [7:0] packet_level;
        logic [7:0] packet_pot;
        logic [7:0] packet_divider;
        logic [7:0] packet_retry_limit;
        logic [9:0] sample_raw;
    } t_in_word;

    typedef struct packed {
        logic [1:0] send_kind;
        logic [7:0] send_parent;
        logic [7:0] send_level;
        logic [2:0] send_hops;
        logic [7:0] send_reading;
        logic       pot_load;
        logic [7:0] pot_value;
        logic       neighbor_write;
        logic [2:0] neighbor_slot;
        logic [3:0] neighbor_id;
    } t_out_word;

endpackage

// ===== rtl/core/trps_if.sv =====
// Valid/ready channel interfaces for the input and result words.
interface trps_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] last_hop_source;
    logic [7:0] next_hop_source;
    logic [2:0] hops_seen;
    logic [7:0] packet_level;
    logic [7:0] packet_pot;
    logic [7:0] packet_divider;
    logic [7:0] packet_retry_limit;
    logic [9:0] sample_raw;

    modport source (
        output valid, command, last_hop_source, next_hop_source, hops_seen,
               packet_level, packet_pot, packet_divider, packet_retry_limit, sample_raw,
        input  ready
    );
    modport sink (
        input  valid, command, last_hop_source, next_hop_source, hops_seen,
               packet_level, packet_pot, packet_divider, packet_retry_limit, sample_raw,
        output ready
    );
endinterface

interface trps_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] send_kind;
    logic [7:0] send_parent;
    logic [7:0] send_level;
    logic [2:0] send_hops;
    logic [7:0] send_reading;
    logic       pot_load;
    logic [7:0] pot_value;
    logic       neighbor_write;
    logic [2:0] neighbor_slot;
    logic [3:0] neighbor_id;

    modport source (
        output valid, send_kind, send_parent, send_level, send_hops, send_reading,
               pot_load, pot_value, neighbor_write, neighbor_slot, neighbor_id,
        input  ready
    );
    modport sink (
        input  valid, send_kind, send_parent, send_level, send_hops, send_reading,
               pot_load, pot_value, neighbor_write, neighbor_slot, neighbor_id,
        output ready
    );
endinterface

// ===== rtl/core/trps_cfg.sv =====
// Configuration register file.
module trps_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [trps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [trps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output trps_pkg::t_cfg                      o_cfg,
    output logic [7:0]                          o_init_divider,
    output logic [7:0]                          o_init_retry
);

    logic [3:0] r_node_address;
    logic [7:0] r_init_divider;
    logic [7:0] r_init_retry;
    logic [7:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address <= trps_pkg::NODE_ADDR_RST;
            r_init_divider <= trps_pkg::DIVIDER_RST;
            r_init_retry   <= trps_pkg::RETRY_RST;
            r_threshold    <= trps_pkg::THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (trps_pkg::t_cfg_idx'(i_cfg_idx))
                trps_pkg::CFG_NODE_ADDRESS: r_node_address <= i_cfg_data[3:0];
                trps_pkg::CFG_INIT_DIVIDER: r_init_divider <= i_cfg_data;
                trps_pkg::CFG_INIT_RETRY:   r_init_retry   <= i_cfg_data;
                trps_pkg::CFG_THRESHOLD:    r_threshold    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.node_address     = r_node_address;
    assign o_cfg.change_threshold = r_threshold;
    assign o_init_divider         = r_init_divider;
    assign o_init_retry           = r_init_retry;

endmodule

// ===== rtl/core/trps_engine.sv =====
// Routing state registers and the single-pass update logic for one word.
module trps_engine #(
    parameter int NEIGHBOR_SLOTS = trps_pkg::NEIGHBOR_SLOTS_DEF,
    parameter int MAX_NODES      = trps_pkg::MAX_NODES_DEF,
    parameter int HOP_SLOTS      = trps_pkg::HOP_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  trps_pkg::t_in_word  i_word,
    input  trps_pkg::t_cfg      i_cfg,
    input  logic [7:0]          i_init_divider,
    input  logic [7:0]          i_init_retry,
    output trps_pkg::t_out_word o_word
);

    localparam int RING_W = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;

    logic [7:0]        r_parent,      n_parent;
    logic [7:0]        r_level,       n_level;
    logic [7:0]        r_cand_parent, n_cand_parent;
    logic [7:0]        r_cand_level,  n_cand_level;
    logic [3:0]        r_route,       n_route;
    logic [7:0]        r_retry,       n_retry;
    logic [7:0]        r_retry_limit, n_retry_limit;
    logic [2:0]        r_beacon,      n_beacon;
    logic [7:0]        r_div,         n_div;
    logic [7:0]        r_div_limit,   n_div_limit;
    logic [7:0]        r_reading,     n_reading;
    logic [RING_W-1:0] r_ring,        n_ring;
    logic [7:0]        r_pot,         n_pot;

    logic [7:0]        node_ext;
    logic [RING_W+2:0] slot_ext;
    logic [4:0]        hop_inc;
    logic [8:0]        new_level;
    logic [7:0]        sample_val;
    logic [7:0]        change_mag;
    trps_pkg::t_out_word res;

    assign node_ext = {4'b0000, i_cfg.node_address};
    assign slot_ext = {3'b000, r_ring};

    always_comb begin
        n_parent      = r_parent;
        n_level       = r_level;
        n_cand_parent = r_cand_parent;
        n_cand_level  = r_cand_level;
        n_route       = r_route;
        n_retry       = r_retry;
        n_retry_limit = r_retry_limit;
        n_beacon      = r_beacon;
        n_div         = r_div;
        n_div_limit   = r_div_limit;
        n_reading     = r_reading;
        n_ring        = r_ring;
        n_pot         = r_pot;
        res           = '0;
        hop_inc       = {2'b00, i_word.hops_seen} + 5'd1;
        new_level     = {1'b0, r_cand_level} + 9'd1;
        sample_val    = i_word.sample_raw[9:2];
        change_mag    = (r_reading >= sample_val) ? (r_reading - sample_val)
                                                  : (sample_val - r_reading);
        if (hop_inc > 5'(HOP_SLOTS - 1)) begin
            hop_inc = 5'(HOP_SLOTS - 1);
        end

        case (trps_pkg::t_cmd'(i_word.command))
            trps_pkg::CMD_MESSAGE: begin
                // Track the candidate parent and log the neighbor
                if (i_word.last_hop_source < 8'(MAX_NODES) &&
                    i_word.last_hop_source != node_ext) begin
                    if (r_cand_level > i_word.packet_level &&
                        i_word.packet_level < trps_pkg::LEVEL_CAP) begin
                        n_cand_level  = i_word.packet_level;
                        n_cand_parent = i_word.last_hop_source;
                    end
                    if (n_cand_level == i_word.packet_level &&
                        r_parent == i_word.last_hop_source) begin
                        n_cand_parent = i_word.last_hop_source;
                    end
                    res.neighbor_write = 1'b1;
                    res.neighbor_slot  = slot_ext[2:0];
                    res.neighbor_id    = i_word.last_hop_source[3:0];
                    n_ring = (r_ring == RING_W'(NEIGHBOR_SLOTS - 1)) ? '0 : r_ring + 1'b1;
                end
                // Forward a message addressed here
                if (i_word.next_hop_source == node_ext && r_parent != trps_pkg::NO_ADDR &&
                    i_word.packet_level > r_level) begin
                    n_beacon           = trps_pkg::FWD_HOLD;
                    res.send_kind      = trps_pkg::SEND_FORWARD;
                    res.send_parent    = r_parent;
                    res.send_level     = r_level;
                    res.send_hops      = hop_inc[2:0];
                    res.send_reading   = r_reading;
                end
                // One-time setup adoption
                if (r_pot == 8'd0 && i_word.packet_pot > trps_pkg::POT_LOW &&
                    i_word.packet_pot < trps_pkg::POT_HIGH) begin
                    n_pot         = i_word.packet_pot;
                    n_div_limit   = i_word.packet_divider;
                    n_retry_limit = i_word.packet_retry_limit;
                    res.pot_load  = 1'b1;
                    res.pot_value = i_word.packet_pot;
                end
            end
            trps_pkg::CMD_TICK: begin
                if (r_div != 8'd0) begin
                    n_div = r_div - 8'd1;
                end else begin
                    n_div   = r_div_limit;
                    n_route = (r_route != 4'd0) ? r_route - 4'd1 : 4'd0;
                    if ((n_route == 4'd0 || r_parent == trps_pkg::NO_ADDR) &&
                        r_cand_parent != trps_pkg::NO_ADDR) begin
                        n_route = trps_pkg::ROUTE_RELOAD;
                        if (new_level < {1'b0, r_level} || r_retry == 8'd0) begin
                            n_parent      = r_cand_parent;
                            n_level       = new_level[8] ? 8'hff : new_level[7:0];
                            n_cand_level  = trps_pkg::LEVEL_NONE;
                            n_cand_parent = trps_pkg::NO_ADDR;
                            n_retry       = r_retry_limit;
                        end else begin
                            n_retry = r_retry - 8'd1;
                        end
                    end
                    n_beacon = (r_beacon != 3'd0) ? r_beacon - 3'd1 : 3'd0;
                    if (n_beacon == 3'd0 && n_parent != trps_pkg::NO_ADDR) begin
                        n_beacon           = trps_pkg::BEACON_PERIOD;
                        res.send_kind      = trps_pkg::SEND_BEACON;
                        res.send_parent    = n_parent;
                        res.send_level     = n_level;
                        res.send_hops      = trps_pkg::BEACON_HOPS;
                        res.send_reading   = r_reading;
                    end
                end
            end
            trps_pkg::CMD_SAMPLE: begin
                if (change_mag > i_cfg.change_threshold) begin
                    n_beacon = 3'd0;
                end
                n_reading = sample_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parent      <= trps_pkg::NO_ADDR;
            r_level       <= trps_pkg::LEVEL_RESET;
            r_cand_parent <= trps_pkg::NO_ADDR;
            r_cand_level  <= trps_pkg::LEVEL_NONE;
            r_route       <= '0;
            r_retry       <= '0;
            r_retry_limit <= trps_pkg::RETRY_RST;
            r_beacon      <= '0;
            r_div         <= '0;
            r_div_limit   <= trps_pkg::DIVIDER_RST;
            r_reading     <= '0;
            r_ring        <= '0;
            r_pot         <= '0;
        end else if (i_step) begin
            r_parent      <= n_parent;
            r_level       <= n_level;
            r_cand_parent <= n_cand_parent;
            r_cand_level  <= n_cand_level;
            r_route       <= n_route;
            r_retry       <= n_retry;
            r_retry_limit <= n_retry_limit;
            r_beacon      <= n_beacon;
            r_div         <= n_div;
            r_div_limit   <= n_div_limit;
            r_reading     <= n_reading;
            r_ring        <= n_ring;
            r_pot         <= n_pot;
        end
    end

    assign o_word = res;

    // The engine loads its divider and retry limits at reset from their own reset constants;
    // later writes to the init registers have no effect on the engine.
    logic unused_init;
    assign unused_init = ^{i_init_divider, i_init_retry};

endmodule

// ===== rtl/core/trps_out_reg.sv =====
// Result register: holds one word until the downstream side takes it.
module trps_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  trps_pkg::t_out_word i_word,
    output logic                o_can_take,
    trps_out_if.source          o_out
);

    logic                r_valid;
    trps_pkg::t_out_word r_word;

    assign o_can_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_push) begin
            r_word <= i_word;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.send_kind      = r_word.send_kind;
    assign o_out.send_parent    = r_word.send_parent;
    assign o_out.send_level     = r_word.send_level;
    assign o_out.send_hops      = r_word.send_hops;
    assign o_out.send_reading   = r_word.send_reading;
    assign o_out.pot_load       = r_word.pot_load;
    assign o_out.pot_value      = r_word.pot_value;
    assign o_out.neighbor_write = r_word.neighbor_write;
    assign o_out.neighbor_slot  = r_word.neighbor_slot;
    assign o_out.neighbor_id    = r_word.neighbor_id;

endmodule

// ===== rtl/core/tree_routing_parent_selector_core.sv =====
// Top level of the tree routing parent selector: input register, engine, result register.
// Path: the input register feeds the engine, whose result word is registered for o_out.
// Throughput: one word per cycle while the result register is not stalled; the whole state
//   update is one pass of compare and counter logic between the input and result registers.
// A stalled result register holds the engine; the input register still takes one word.
// Reset (synchronous, active low) clears both valid flags and loads all routing state
//   and configuration registers with their reset values; there is no clearing pass.
module tree_routing_parent_selector_core #(
    parameter int NEIGHBOR_SLOTS = trps_pkg::NEIGHBOR_SLOTS_DEF,
    parameter int MAX_NODES      = trps_pkg::MAX_NODES_DEF,
    parameter int HOP_SLOTS      = trps_pkg::HOP_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [trps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [trps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    trps_in_if.sink                         i_in,
    trps_out_if.source                      o_out
);

    trps_pkg::t_cfg      cfg;
    logic [7:0]          init_divider;
    logic [7:0]          init_retry;

    // Input register
    logic                r_in_valid;
    trps_pkg::t_in_word  r_in_word;
    trps_pkg::t_in_word  in_word;

    trps_pkg::t_out_word step_word;
    logic                out_can_take;
    logic                step;
    logic                in_take;

    // Advance the held word into the engine when the result register has room
    assign step    = r_in_valid && out_can_take;
    assign i_in.ready = !r_in_valid || step;
    assign in_take = i_in.valid && i_in.ready;

    assign in_word.command            = i_in.command;
    assign in_word.last_hop_source    = i_in.last_hop_source;
    assign in_word.next_hop_source    = i_in.next_hop_source;
    assign in_word.hops_seen          = i_in.hops_seen;
    assign in_word.packet_level       = i_in.packet_level;
    assign in_word.packet_pot         = i_in.packet_pot;
    assign in_word.packet_divider     = i_in.packet_divider;
    assign in_word.packet_retry_limit = i_in.packet_retry_limit;
    assign in_word.sample_raw         = i_in.sample_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Payload needs no reset; load only on an accepted word
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= in_word;
        end
    end

    trps_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_cfg          (cfg),
        .o_init_divider (init_divider),
        .o_init_retry   (init_retry)
    );

    // Update routing state and build the result word in one pass
    trps_engine #(
        .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS),
        .MAX_NODES      (MAX_NODES),
        .HOP_SLOTS      (HOP_SLOTS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_word         (r_in_word),
        .i_cfg          (cfg),
        .i_init_divider (init_divider),
        .i_init_retry   (init_retry),
        .o_word         (step_word)
    );

    // Hold the result word until downstream takes it
    trps_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (step),
        .i_word     (step_word),
        .o_can_take (out_can_take),
        .o_out      (o_out)
    );

endmodule

// ===== rtl/core/trps_chk.sv =====
// Port-level checker for the tree routing parent selector, bound to the top level.
module trps_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [1:0] i_send_kind,
    input logic [7:0] i_send_parent,
    input logic [7:0] i_send_level,
    input logic [2:0] i_send_hops,
    input logic [7:0] i_send_reading,
    input logic       i_pot_load,
    input logic [7:0] i_pot_value,
    input logic       i_neighbor_write,
    input logic [2:0] i_neighbor_slot,
    input logic [3:0] i_neighbor_id
);

    // No result word right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // A stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_send_kind) && $stable(i_send_parent)
            && $stable(i_neighbor_slot) && $stable(i_pot_value))
        else $error("stalled result word changed");

    // Nothing sent means empty send fields
    a_idle_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_send_kind == trps_pkg::SEND_NONE |->
            i_send_parent == 8'd0 && i_send_level == 8'd0 && i_send_hops == 3'd0
            && i_send_reading == 8'd0)
        else $error("send fields set with nothing sent");

    // A beacon carries a hop count of one and a real parent
    a_beacon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_send_kind == trps_pkg::SEND_BEACON |->
            i_send_hops == trps_pkg::BEACON_HOPS && i_send_parent != trps_pkg::NO_ADDR)
        else $error("malformed beacon");

    // Side fields are zero unless flagged
    a_side_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_pot_load || i_pot_value == 8'd0) && (i_neighbor_write ||
            (i_neighbor_slot == 3'd0 && i_neighbor_id == 4'd0)))
        else $error("unflagged side field set");

endmodule

bind tree_routing_parent_selector_core trps_chk u_trps_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_out.valid),
    .i_ready          (o_out.ready),
    .i_send_kind      (o_out.send_kind),
    .i_send_parent    (o_out.send_parent),
    .i_send_level     (o_out.send_level),
    .i_send_hops      (o_out.send_hops),
    .i_send_reading   (o_out.send_reading),
    .i_pot_load       (o_out.pot_load),
    .i_pot_value      (o_out.pot_value),
    .i_neighbor_write (o_out.neighbor_write),
    .i_neighbor_slot  (o_out.neighbor_slot),
    .i_neighbor_id    (o_out.neighbor_id)
);
